/* src/dual_motor_fault_monitor_macros.svh */
// Assertion macros used by the RTL.
`ifndef DUAL_MOTOR_FAULT_MONITOR_MACROS_SVH
`define DUAL_MOTOR_FAULT_MONITOR_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define DMFM_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dmfm: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define DMFM_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dmfm: next-cycle check failed");

`endif

/* src/dmfm_pkg.sv */
`default_nettype none

package dmfm_pkg;

  localparam int DT_W       = 8;
  localparam int CUR_W      = 16;
  localparam int SPD_W      = 16;
  localparam int DUTY_W     = 11;
  localparam int LIMIT_W    = 15;
  localparam int DWELL_W    = 20;
  localparam int DUTYMIN_W  = 10;
  localparam int SPDTH_W    = 15;
  localparam int STUCK_W    = 16;
  localparam int FLAG_W     = 7;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OVERCURRENT_LIMIT = 3'd0,
    REG_OVERCURRENT_DWELL = 3'd1,
    REG_STALL_DUTY_MIN    = 3'd2,
    REG_STALL_SPEED_MAX   = 3'd3,
    REG_STALL_DWELL       = 3'd4,
    REG_ENCODER_SPEED_MIN = 3'd5,
    REG_ENCODER_TIMEOUT   = 3'd6,
    REG_ADC_STUCK_SAMPLES = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [LIMIT_W-1:0]   overcurrent_limit_ma;
    logic [DWELL_W-1:0]   overcurrent_dwell_ms;
    logic [DUTYMIN_W-1:0] stall_duty_min;
    logic [SPDTH_W-1:0]   stall_speed_max;
    logic [DWELL_W-1:0]   stall_dwell_ms;
    logic [SPDTH_W-1:0]   encoder_speed_min;
    logic [DWELL_W-1:0]   encoder_timeout_ms;
    logic [STUCK_W-1:0]   adc_stuck_samples;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    overcurrent_limit_ma: 15'd5000,
    overcurrent_dwell_ms: 20'd200,
    stall_duty_min:       10'd500,
    stall_speed_max:      15'd50,
    stall_dwell_ms:       20'd500,
    encoder_speed_min:    15'd100,
    encoder_timeout_ms:   20'd500,
    adc_stuck_samples:    16'd50
  };

  // Per-motor sample carried into a side unit.
  typedef struct packed {
    logic [CUR_W-1:0]  current_ma;
    logic [SPD_W-1:0]  speed;
    logic [SPD_W-1:0]  target;
    logic [DUTY_W-1:0] duty;
  } side_in_t;

  typedef struct packed {
    logic encoder;
    logic stall;
    logic overcurrent;
  } side_flags_t;

  function automatic logic [SPD_W-1:0] abs_spd(input logic [SPD_W-1:0] v);
    abs_spd = v[SPD_W-1] ? (~v + 1'b1) : v;
  endfunction

  function automatic logic [DUTY_W-1:0] abs_duty(input logic [DUTY_W-1:0] v);
    abs_duty = v[DUTY_W-1] ? (~v + 1'b1) : v;
  endfunction

endpackage

`default_nettype wire

/* src/dual_motor_fault_monitor.sv */
`default_nettype none

// Dual motor fault monitor. Each input transaction is one monitor tick for
// both motors; each tick yields exactly one output transaction carrying the
// seven-bit fault word (bits 0/1 overcurrent L/R, 2/3 stall L/R, 4/5 encoder
// timeout L/R, 6 ADC stuck). Per motor, three dwell timers accumulate
// elapsed_ms while their condition holds, clear when it drops, and saturate
// at full scale; a fault bit is set while its timer is at or above the
// programmed dwell. The ADC-stuck counter counts ticks on which both raw
// samples are railed or both repeat the previous tick, but only while the
// current is valid and either absolute duty reaches ADC_MIN_DUTY. The block
// accepts one tick per clock and sustains one result per clock: a tick is
// captured in the input register, the timers and the stuck counter are
// updated as it moves on, and its fault word is captured in the output
// register, which raises out_valid. A stalled output holds both stages;
// the input side keeps taking ticks as long as the input register can
// drain. Write configuration registers through cfg_we / cfg_index /
// cfg_data only while no tick is in flight; there is no read-back.
// No clearing pass is needed after reset.

`include "dual_motor_fault_monitor_macros.svh"

module dual_motor_fault_monitor #(
  parameter int ADC_BITS     = 12,
  parameter int TIMER_BITS   = 20,
  parameter int RAIL_MARGIN  = 16,
  parameter int ADC_MIN_DUTY = 50
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // configuration write port
  input  wire logic                            cfg_we,
  input  wire logic [dmfm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [dmfm_pkg::CFG_DATA_W-1:0] cfg_data,
  // tick input channel
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [dmfm_pkg::DT_W-1:0]       elapsed_ms,
  input  wire logic signed [dmfm_pkg::CUR_W-1:0]  current_left_ma,
  input  wire logic signed [dmfm_pkg::CUR_W-1:0]  current_right_ma,
  input  wire logic signed [dmfm_pkg::SPD_W-1:0]  speed_left,
  input  wire logic signed [dmfm_pkg::SPD_W-1:0]  speed_right,
  input  wire logic signed [dmfm_pkg::SPD_W-1:0]  target_left,
  input  wire logic signed [dmfm_pkg::SPD_W-1:0]  target_right,
  input  wire logic signed [dmfm_pkg::DUTY_W-1:0] duty_left,
  input  wire logic signed [dmfm_pkg::DUTY_W-1:0] duty_right,
  input  wire logic                            current_valid,
  input  wire logic [ADC_BITS-1:0]             adc_left,
  input  wire logic [ADC_BITS-1:0]             adc_right,
  // fault word output channel
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [dmfm_pkg::FLAG_W-1:0]          fault_flags
);
  import dmfm_pkg::*;

  // Rail thresholds; an oversized margin pulls the upper rail down to zero.
  localparam int AdcFull = (1 << ADC_BITS) - 1;
  localparam int RailHi  = (AdcFull > RAIL_MARGIN) ? (AdcFull - RAIL_MARGIN) : 0;
  localparam logic [31:0]       RailLoU   = 32'(RAIL_MARGIN);
  localparam logic [31:0]       RailHiU   = 32'(RailHi);
  localparam logic [DUTY_W-1:0] MinDuty   = DUTY_W'(ADC_MIN_DUTY);
  localparam logic [STUCK_W-1:0] StuckMax = '1;

  cfg_t cfg;

  // Input register stage.
  logic                  s1_valid;
  logic [DT_W-1:0]       s1_dt;
  side_in_t              s1_left, s1_right;
  logic                  s1_current_valid;
  logic [ADC_BITS-1:0]   s1_adc_left, s1_adc_right;

  // Detector state.
  logic [ADC_BITS-1:0]   prev_adc_left, prev_adc_right;
  logic [STUCK_W-1:0]    stuck_cnt, stuck_cnt_next;

  logic                  advance;
  logic                  step;
  logic                  stuck_active, rails, same, stuck_flag;
  side_flags_t           flags_left, flags_right;
  logic [FLAG_W-1:0]     fault_flags_next;

  function automatic logic is_railed(input logic [ADC_BITS-1:0] s);
    logic [31:0] w;
    w = {{(32 - ADC_BITS){1'b0}}, s};
    is_railed = (w <= RailLoU) || (w >= RailHiU);
  endfunction

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_OVERCURRENT_LIMIT: cfg.overcurrent_limit_ma <= cfg_data[LIMIT_W-1:0];
        REG_OVERCURRENT_DWELL: cfg.overcurrent_dwell_ms <= cfg_data[DWELL_W-1:0];
        REG_STALL_DUTY_MIN:    cfg.stall_duty_min       <= cfg_data[DUTYMIN_W-1:0];
        REG_STALL_SPEED_MAX:   cfg.stall_speed_max      <= cfg_data[SPDTH_W-1:0];
        REG_STALL_DWELL:       cfg.stall_dwell_ms       <= cfg_data[DWELL_W-1:0];
        REG_ENCODER_SPEED_MIN: cfg.encoder_speed_min    <= cfg_data[SPDTH_W-1:0];
        REG_ENCODER_TIMEOUT:   cfg.encoder_timeout_ms   <= cfg_data[DWELL_W-1:0];
        REG_ADC_STUCK_SAMPLES: cfg.adc_stuck_samples    <= cfg_data[STUCK_W-1:0];
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------------- handshake
  // Advance whenever the output register is empty or being drained; the
  // input register then frees up in the same cycle.
  assign advance  = !out_valid || out_ready;
  assign in_ready = !s1_valid || advance;
  assign step     = s1_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  // Payload capture; no reset needed.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_dt               <= elapsed_ms;
      s1_left.current_ma  <= current_left_ma;
      s1_left.speed       <= speed_left;
      s1_left.target      <= target_left;
      s1_left.duty        <= duty_left;
      s1_right.current_ma <= current_right_ma;
      s1_right.speed      <= speed_right;
      s1_right.target     <= target_right;
      s1_right.duty       <= duty_right;
      s1_current_valid    <= current_valid;
      s1_adc_left         <= adc_left;
      s1_adc_right        <= adc_right;
    end
  end

  // ----------------------------------------------------------- dwell timers
  dmfm_side #(.TIMER_BITS(TIMER_BITS)) u_side_left (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .dt     (s1_dt),
    .sample (s1_left),
    .cfg    (cfg),
    .flags  (flags_left)
  );

  dmfm_side #(.TIMER_BITS(TIMER_BITS)) u_side_right (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .dt     (s1_dt),
    .sample (s1_right),
    .cfg    (cfg),
    .flags  (flags_right)
  );

  // ------------------------------------------------------- ADC stuck detect
  // Count only while the current is valid and at least one side drives hard
  // enough; otherwise drop the count and keep the stuck bit low.
  assign stuck_active = s1_current_valid
                        && ((abs_duty(s1_left.duty) >= MinDuty)
                            || (abs_duty(s1_right.duty) >= MinDuty));
  assign rails = is_railed(s1_adc_left) && is_railed(s1_adc_right);
  assign same  = (s1_adc_left == prev_adc_left) && (s1_adc_right == prev_adc_right);

  always_comb begin
    if (!stuck_active || !(rails || same)) begin
      stuck_cnt_next = '0;
    end else if (stuck_cnt == StuckMax) begin
      stuck_cnt_next = stuck_cnt;
    end else begin
      stuck_cnt_next = stuck_cnt + 1'b1;
    end
  end

  assign stuck_flag = stuck_active && (stuck_cnt_next >= cfg.adc_stuck_samples);

  always_ff @(posedge clk) begin
    if (rst) begin
      stuck_cnt      <= '0;
      prev_adc_left  <= '0;
      prev_adc_right <= '0;
    end else if (step) begin
      stuck_cnt      <= stuck_cnt_next;
      prev_adc_left  <= s1_adc_left;
      prev_adc_right <= s1_adc_right;
    end
  end

  // --------------------------------------------------------- output register
  assign fault_flags_next = {stuck_flag,
                             flags_right.encoder,     flags_left.encoder,
                             flags_right.stall,       flags_left.stall,
                             flags_right.overcurrent, flags_left.overcurrent};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      fault_flags <= fault_flags_next;
    end
  end

  // ------------------------------------------------------------- assertions
  `DMFM_ASSERT_IMP(a_ready_when_empty, clk, rst, !s1_valid, in_ready)
  `DMFM_ASSERT_NXT(a_accept_fills_stage, clk, rst, in_valid && in_ready, s1_valid)
  `DMFM_ASSERT_NXT(a_step_makes_result, clk, rst, step, out_valid)
  `DMFM_ASSERT_NXT(a_idle_clears_stuck, clk, rst, step && !stuck_active, stuck_cnt == '0)

endmodule

`default_nettype wire

/* src/dmfm_side.sv */
`default_nettype none

module dmfm_side #(
  parameter int TIMER_BITS = 20
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      step,
  input  wire logic [dmfm_pkg::DT_W-1:0] dt,
  input  wire dmfm_pkg::side_in_t        sample,
  input  wire dmfm_pkg::cfg_t            cfg,
  output dmfm_pkg::side_flags_t          flags
);
  import dmfm_pkg::*;

  localparam int CMP_W = (TIMER_BITS > DWELL_W) ? TIMER_BITS : DWELL_W;

  logic [TIMER_BITS-1:0] oc_time, stall_time, enc_time;
  logic [TIMER_BITS-1:0] oc_time_next, stall_time_next, enc_time_next;
  logic [SPD_W-1:0]      abs_speed, abs_target;
  logic                  oc_cond, stall_cond, enc_cond;

  function automatic logic [TIMER_BITS-1:0] dwell_add(
    input logic [TIMER_BITS-1:0] t,
    input logic                  cond,
    input logic [DT_W-1:0]       d
  );
    logic [TIMER_BITS:0] sum;
    sum = {1'b0, t} + {{(TIMER_BITS + 1 - DT_W){1'b0}}, d};
    if (!cond) begin
      dwell_add = '0;
    end else if (sum[TIMER_BITS]) begin
      dwell_add = '1;
    end else begin
      dwell_add = sum[TIMER_BITS-1:0];
    end
  endfunction

  assign abs_speed  = abs_spd(sample.speed);
  assign abs_target = abs_spd(sample.target);

  assign oc_cond    = $signed(sample.current_ma) > $signed({1'b0, cfg.overcurrent_limit_ma});
  assign stall_cond = ($signed(sample.duty) >= $signed({1'b0, cfg.stall_duty_min}))
                      && (abs_speed <= {1'b0, cfg.stall_speed_max});
  assign enc_cond   = (abs_target >= {1'b0, cfg.encoder_speed_min})
                      && (abs_speed <= {1'b0, cfg.encoder_speed_min});

  assign oc_time_next    = dwell_add(oc_time, oc_cond, dt);
  assign stall_time_next = dwell_add(stall_time, stall_cond, dt);
  assign enc_time_next   = dwell_add(enc_time, enc_cond, dt);

  always_comb begin
    flags.overcurrent = CMP_W'(oc_time_next) >= CMP_W'(cfg.overcurrent_dwell_ms);
    flags.stall       = CMP_W'(stall_time_next) >= CMP_W'(cfg.stall_dwell_ms);
    flags.encoder     = CMP_W'(enc_time_next) >= CMP_W'(cfg.encoder_timeout_ms);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      oc_time    <= '0;
      stall_time <= '0;
      enc_time   <= '0;
    end else if (step) begin
      oc_time    <= oc_time_next;
      stall_time <= stall_time_next;
      enc_time   <= enc_time_next;
    end
  end

endmodule

`default_nettype wire
